>>> design/jfci_pkg.sv
// Package for the JEDEC flash command interface: array geometry, unlock
// addresses, command bytes, effect codes, sequence states and array port type.
// No dependencies.
package jfci_pkg;

  localparam int ARRAY_BYTES      = 262144;
  localparam int ADDR_W           = 18;
  localparam int IDX_W            = $clog2(ARRAY_BYTES);
  localparam int UNLOCK_ADDR_BITS = 11;
  localparam int DATA_W           = 8;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_ADDR_W       = 3;

  localparam logic [UNLOCK_ADDR_BITS-1:0] UNLOCK_A = UNLOCK_ADDR_BITS'(16'h5555);
  localparam logic [UNLOCK_ADDR_BITS-1:0] UNLOCK_B = UNLOCK_ADDR_BITS'(16'h2AAA);

  // command bytes
  localparam logic [DATA_W-1:0] CB_UNLOCK1 = 8'hAA;
  localparam logic [DATA_W-1:0] CB_UNLOCK2 = 8'h55;
  localparam logic [DATA_W-1:0] CB_ID      = 8'h90;
  localparam logic [DATA_W-1:0] CB_RESET   = 8'hF0;
  localparam logic [DATA_W-1:0] CB_ERASE   = 8'h80;
  localparam logic [DATA_W-1:0] CB_CHIP    = 8'h10;
  localparam logic [DATA_W-1:0] CB_PROGRAM = 8'hA0;
  localparam logic [DATA_W-1:0] ERASED     = 8'hFF;

  // bus access kind
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // configuration register index (paddr[2])
  localparam logic CFG_MFR_ID = 1'b0;
  localparam logic CFG_DEV_ID = 1'b1;

  // ID byte offsets
  localparam logic [7:0] ID_OFS_MFR = 8'h00;
  localparam logic [7:0] ID_OFS_DEV = 8'h01;

  localparam logic [DATA_W-1:0] MFR_ID_RST = 8'hC2;
  localparam logic [DATA_W-1:0] DEV_ID_RST = 8'hB0;

  typedef enum logic [2:0] {
    FX_NONE   = 3'd0,
    FX_RESET  = 3'd1,
    FX_ID     = 3'd2,
    FX_PROG   = 3'd3,
    FX_ERASE  = 3'd4,
    FX_BROKEN = 3'd5
  } fx_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_U1     = 7'b0000010,
    ST_U2     = 7'b0000100,
    ST_ERS    = 7'b0001000,
    ST_ERS_U1 = 7'b0010000,
    ST_ERS_U2 = 7'b0100000,
    ST_PROG   = 7'b1000000
  } stage_t;

  // one access to the byte array: read, write-back or chip erase start
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              erase;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] wdata;
  } arr_req_t;

endpackage

>>> design/jfci_in_if.sv
// Bus access channel: valid/ready handshake with command, address and data.
// Depends on jfci_pkg.
interface jfci_in_if;
  import jfci_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] data;

  modport source (output valid, command, address, data, input ready);
  modport sink   (input valid, command, address, data, output ready);
endinterface

>>> design/jfci_out_if.sv
// Result channel: valid/ready handshake with read data, write effect and ID flag.
// Depends on jfci_pkg.
interface jfci_out_if;
  import jfci_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [2:0]        write_effect;
  logic              in_id_mode;

  modport source (output valid, read_data, write_effect, in_id_mode, input ready);
  modport sink   (input valid, read_data, write_effect, in_id_mode, output ready);
endinterface

>>> design/jfci_array.sv
// Flash byte array: single-port synchronous RAM with registered read data and
// a fill sweep that writes the erased value after reset and on chip erase.
// Depends on jfci_pkg.
module jfci_array (
  input  logic                       clk,
  input  logic                       rst_n,
  input  jfci_pkg::arr_req_t         req,
  output logic [jfci_pkg::DATA_W-1:0] rdata,
  output logic                       clearing
);
  import jfci_pkg::*;

  logic [DATA_W-1:0] mem [ARRAY_BYTES];
  logic [DATA_W-1:0] rdata_r;
  logic              clr_busy_r, clr_busy_nxt;
  logic [IDX_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdat;

  assign we    = clr_busy_r | req.wr_en;
  assign waddr = clr_busy_r ? clr_cnt_r : req.addr;
  assign wdat  = clr_busy_r ? ERASED : req.wdata;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == IDX_W'(ARRAY_BYTES - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end else if (req.erase) begin
      clr_busy_nxt = 1'b1;
      clr_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdat;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata    = rdata_r;
  assign clearing = clr_busy_r;
endmodule

>>> design/jedec_flash_command_interface.sv
// Parallel NOR flash with the JEDEC command set, seen from its bus. A bus access
// reads the addressed byte from the single-port array RAM when it is accepted,
// then decodes the command sequence and writes a programmed byte back (old AND
// new) when it completes; completion waits while an untaken beat is held. The
// result beat sits in an output register, so the next access is taken while it
// waits. After reset, and after every chip erase, the array is filled with 0xFF
// one byte per cycle; in_ch.ready stays low during that fill. ID bytes are set
// through the APB port (manufacturer at 0x0, device at 0x4).
module jedec_flash_command_interface (
  input  logic                            clk,
  input  logic                            rst_n,
  jfci_in_if.sink                         in_ch,
  jfci_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [jfci_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [jfci_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [jfci_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import jfci_pkg::*;

  logic              mfr_id_r, unused_bit;
  logic [DATA_W-1:0] mfr_r, dev_r;
  logic              cfg_wr;

  logic              busy_r;
  logic              cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] data_r;
  stage_t            stage_r, stage_nxt;
  logic              id_r, id_nxt;
  fx_t               fx;
  logic [DATA_W-1:0] rd;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_rd_r;
  fx_t               out_fx_r;
  logic              out_id_r;

  arr_req_t          req;
  logic [DATA_W-1:0] mem_rdata;
  logic              clearing;
  logic              acc, done;
  logic              at_a, at_b;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign mfr_id_r   = cfg_paddr[2];
  assign unused_bit = ^cfg_pwdata[CFG_DATA_W-1:DATA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mfr_r <= MFR_ID_RST;
      dev_r <= DEV_ID_RST;
    end else if (cfg_wr) begin
      if (mfr_id_r == CFG_MFR_ID) begin
        mfr_r <= cfg_pwdata[DATA_W-1:0];
      end else begin
        dev_r <= cfg_pwdata[DATA_W-1:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (mfr_id_r == CFG_DEV_ID) begin
      cfg_prdata = {{(CFG_DATA_W-DATA_W){1'b0}}, dev_r};
    end else begin
      cfg_prdata = {{(CFG_DATA_W-DATA_W){unused_bit & 1'b0}}, mfr_r};
    end
  end

  // handshakes
  assign in_ch.ready = ~busy_r & ~clearing;
  assign acc         = in_ch.valid & in_ch.ready;
  assign done        = busy_r & (~out_valid_r | out_ch.ready);

  // command decode on the captured beat
  assign at_a = (addr_r[UNLOCK_ADDR_BITS-1:0] == UNLOCK_A);
  assign at_b = (addr_r[UNLOCK_ADDR_BITS-1:0] == UNLOCK_B);

  always_comb begin
    stage_nxt = stage_r;
    id_nxt    = id_r;
    fx        = FX_NONE;
    rd        = '0;
    if (cmd_r == CMD_READ) begin
      if (id_r) begin
        if (addr_r[7:0] == ID_OFS_MFR) begin
          rd = mfr_r;
        end else if (addr_r[7:0] == ID_OFS_DEV) begin
          rd = dev_r;
        end
      end else begin
        rd = mem_rdata;
      end
    end else if (stage_r == ST_PROG) begin
      stage_nxt = ST_IDLE;
      id_nxt    = 1'b0;
      fx        = FX_PROG;
    end else if (data_r == CB_RESET) begin
      stage_nxt = ST_IDLE;
      id_nxt    = 1'b0;
      fx        = FX_RESET;
    end else begin
      // default: sequence broken, drop back to idle
      stage_nxt = ST_IDLE;
      fx        = FX_BROKEN;
      case (stage_r)
        ST_IDLE: begin
          if (data_r == CB_UNLOCK1 && at_a) begin
            stage_nxt = ST_U1;
            fx        = FX_NONE;
          end
        end
        ST_U1: begin
          if (data_r == CB_UNLOCK2 && at_b) begin
            stage_nxt = ST_U2;
            fx        = FX_NONE;
          end
        end
        ST_U2: begin
          if (at_a && data_r == CB_ID) begin
            id_nxt = 1'b1;
            fx     = FX_ID;
          end else if (at_a && data_r == CB_PROGRAM) begin
            stage_nxt = ST_PROG;
            fx        = FX_NONE;
          end else if (at_a && data_r == CB_ERASE) begin
            stage_nxt = ST_ERS;
            fx        = FX_NONE;
          end
        end
        ST_ERS: begin
          if (data_r == CB_UNLOCK1 && at_a) begin
            stage_nxt = ST_ERS_U1;
            fx        = FX_NONE;
          end
        end
        ST_ERS_U1: begin
          if (data_r == CB_UNLOCK2 && at_b) begin
            stage_nxt = ST_ERS_U2;
            fx        = FX_NONE;
          end
        end
        ST_ERS_U2: begin
          if (data_r == CB_CHIP && at_a) begin
            id_nxt = 1'b0;
            fx     = FX_ERASE;
          end
        end
        default: begin
          stage_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // array port: read at accept, write back or start erase at completion
  always_comb begin
    req.rd_en = acc;
    req.wr_en = done & (cmd_r == CMD_WRITE) & (fx == FX_PROG);
    req.erase = done & (fx == FX_ERASE);
    req.addr  = busy_r ? addr_r[IDX_W-1:0] : in_ch.address[IDX_W-1:0];
    req.wdata = mem_rdata & data_r;
  end

  jfci_array u_array (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .rdata    (mem_rdata),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r  <= in_ch.command;
      addr_r <= in_ch.address;
      data_r <= in_ch.data;
    end
    if (done) begin
      out_rd_r <= rd;
      out_fx_r <= fx;
      out_id_r <= id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      stage_r     <= ST_IDLE;
      id_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (done) begin
        stage_r     <= stage_nxt;
        id_r        <= id_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_rd_r;
  assign out_ch.write_effect = out_fx_r;
  assign out_ch.in_id_mode   = out_id_r;
endmodule

>>> sim/jedec_flash_command_interface_tb.sv
// Testbench for the JEDEC flash command interface: directed and random bus
// accesses checked beat by beat against a shadow copy of the flash device.
// Depends on jfci_pkg, jfci_in_if, jfci_out_if and the block itself.
module jedec_flash_command_interface_tb;
  import jfci_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic [2:0]        effect;
    logic              id_mode;
  } flash_result_t;

  // Shadow of the device: command stage, ID mode, array contents and ID bytes
  class nor_flash_shadow;
    stage_t            stage;
    logic              id_mode;
    logic [DATA_W-1:0] mfr_id;
    logic [DATA_W-1:0] dev_id;
    logic [DATA_W-1:0] flash_bytes [logic [IDX_W-1:0]];
    flash_result_t     pending_results [$];
    int                errors;
    int                beats;

    function new();
      stage   = ST_IDLE;
      id_mode = 1'b0;
      mfr_id  = MFR_ID_RST;
      dev_id  = DEV_ID_RST;
      errors  = 0;
      beats   = 0;
    endfunction

    function void set_id(logic sel, logic [DATA_W-1:0] val);
      if (sel == CFG_MFR_ID) begin
        mfr_id = val;
      end else begin
        dev_id = val;
      end
    endfunction

    // untouched bytes read as erased
    function logic [DATA_W-1:0] byte_at(logic [IDX_W-1:0] idx);
      return flash_bytes.exists(idx) ? flash_bytes[idx] : ERASED;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void note_access(logic cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      flash_result_t     r;
      logic              at_a;
      logic              at_b;
      logic [IDX_W-1:0]  idx;
      stage_t            nxt;
      r    = '0;
      idx  = IDX_W'(addr % ARRAY_BYTES);
      at_a = (addr[UNLOCK_ADDR_BITS-1:0] == UNLOCK_A);
      at_b = (addr[UNLOCK_ADDR_BITS-1:0] == UNLOCK_B);
      if (cmd == CMD_READ) begin
        if (id_mode) begin
          case (addr[7:0])
            ID_OFS_MFR: r.rdata = mfr_id;
            ID_OFS_DEV: r.rdata = dev_id;
            default:    r.rdata = '0;
          endcase
        end else begin
          r.rdata = byte_at(idx);
        end
      end else begin
        r.effect = FX_BROKEN;
        nxt      = ST_IDLE;
        if (stage == ST_PROG) begin
          flash_bytes[idx] = byte_at(idx) & data;
          r.effect = FX_PROG;
          id_mode  = 1'b0;
        end else if (data == CB_RESET) begin
          r.effect = FX_RESET;
          id_mode  = 1'b0;
        end else begin
          case (stage)
            ST_IDLE: begin
              if (data == CB_UNLOCK1 && at_a) begin
                nxt = ST_U1;
                r.effect = FX_NONE;
              end
            end
            ST_U1: begin
              if (data == CB_UNLOCK2 && at_b) begin
                nxt = ST_U2;
                r.effect = FX_NONE;
              end
            end
            ST_U2: begin
              if (at_a && data == CB_ID) begin
                id_mode  = 1'b1;
                r.effect = FX_ID;
              end else if (at_a && data == CB_PROGRAM) begin
                nxt = ST_PROG;
                r.effect = FX_NONE;
              end else if (at_a && data == CB_ERASE) begin
                nxt = ST_ERS;
                r.effect = FX_NONE;
              end
            end
            ST_ERS: begin
              if (data == CB_UNLOCK1 && at_a) begin
                nxt = ST_ERS_U1;
                r.effect = FX_NONE;
              end
            end
            ST_ERS_U1: begin
              if (data == CB_UNLOCK2 && at_b) begin
                nxt = ST_ERS_U2;
                r.effect = FX_NONE;
              end
            end
            ST_ERS_U2: begin
              if (data == CB_CHIP && at_a) begin
                flash_bytes.delete();
                id_mode  = 1'b0;
                r.effect = FX_ERASE;
              end
            end
            default: ;
          endcase
        end
        stage = nxt;
      end
      r.id_mode = id_mode;
      pending_results.push_back(r);
    endfunction

    task check_beat(logic [DATA_W-1:0] rd, logic [2:0] fx, logic idm);
      flash_result_t want;
      beats++;
      if (pending_results.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing expected", beats));
        return;
      end
      want = pending_results.pop_front();
      if (rd !== want.rdata)
        report($sformatf("beat %0d read_data %02h, expected %02h", beats, rd, want.rdata));
      if (fx !== want.effect)
        report($sformatf("beat %0d write_effect %0d, expected %0d", beats, fx, want.effect));
      if (idm !== want.id_mode)
        report($sformatf("beat %0d in_id_mode %0b, expected %0b", beats, idm, want.id_mode));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  jfci_in_if  access_ch ();
  jfci_out_if result_ch ();

  jedec_flash_command_interface DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (access_ch),
    .out_ch      (result_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  nor_flash_shadow   shadow = new();
  logic [ADDR_W-1:0] hot [16];
  bit                tx_idle = 1'b1;
  bit                rx_idle = 1'b1;
  bit                hold_req = 1'b0;
  int                sent = 0;
  int                cycles = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (access_ch.valid && access_ch.ready)
        shadow.note_access(access_ch.command, access_ch.address, access_ch.data);
      if (result_ch.valid && result_ch.ready)
        shadow.check_beat(result_ch.read_data, result_ch.write_effect, result_ch.in_id_mode);
    end
  end

  // result side: a random stall before each beat while rx_idle is set, or one long hold on request
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 11) : 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        result_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  task automatic send(logic cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      access_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    access_ch.valid   = 1'b1;
    access_ch.command = cmd;
    access_ch.address = addr;
    access_ch.data    = data;
    do @(posedge clk); while (!access_ch.ready);
    sent++;
  endtask

  // drop valid and hold until every result beat is in
  task automatic drain();
    @(negedge clk);
    access_ch.valid = 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic sel, logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {sel, 2'b00};
    cfg_pwdata  = CFG_DATA_W'(val);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    shadow.set_id(sel, val);
    // read back through a second transfer
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DATA_W'(val))
      shadow.report($sformatf("register %0d read %08h, expected %02h", sel, cfg_prdata, val));
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_ids(logic [DATA_W-1:0] mfr, logic [DATA_W-1:0] dev);
    cfg_write(CFG_MFR_ID, mfr);
    cfg_write(CFG_DEV_ID, dev);
  endtask

  function automatic logic [ADDR_W-1:0] unlock_at(logic second);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'($urandom);
    a[UNLOCK_ADDR_BITS-1:0] = second ? UNLOCK_B : UNLOCK_A;
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    logic [ADDR_W-1:0] a;
    a = ADDR_W'($urandom);
    case ($urandom_range(0, 3))
      0, 1: a = hot[$urandom_range(0, 15)];
      2:    a[7:0] = 8'($urandom_range(0, 2));
      default: ;
    endcase
    return a;
  endfunction

  task automatic write_byte(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    // keep stray writes from finishing a chip erase; each erase costs a full fill
    if (data == CB_CHIP && addr[UNLOCK_ADDR_BITS-1:0] == UNLOCK_A)
      addr[0] = ~addr[0];
    send(CMD_WRITE, addr, data);
  endtask

  task automatic read_byte(logic [ADDR_W-1:0] addr);
    send(CMD_READ, addr, DATA_W'($urandom));
  endtask

  task automatic maybe_read();
    if ($urandom_range(0, 4) == 0)
      read_byte(pick_addr());
  endtask

  task automatic unlock();
    write_byte(unlock_at(1'b0), CB_UNLOCK1);
    maybe_read();
    write_byte(unlock_at(1'b1), CB_UNLOCK2);
    maybe_read();
  endtask

  task automatic chip_erase();
    unlock();
    write_byte(unlock_at(1'b0), CB_ERASE);
    unlock();
    send(CMD_WRITE, unlock_at(1'b0), CB_CHIP);
  endtask

  task automatic random_sequence();
    int                kind;
    int                k;
    logic [DATA_W-1:0] prefix_data [5];
    logic              prefix_b [5];
    prefix_data = '{CB_UNLOCK1, CB_UNLOCK2, CB_ERASE, CB_UNLOCK1, CB_UNLOCK2};
    prefix_b    = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      read_byte(pick_addr());
    end else if (kind < 40) begin
      unlock();
      write_byte(unlock_at(1'b0), CB_ID);
      repeat ($urandom_range(1, 3)) read_byte(pick_addr());
    end else if (kind < 62) begin
      unlock();
      write_byte(unlock_at(1'b0), CB_PROGRAM);
      maybe_read();
      write_byte(pick_addr(), DATA_W'($urandom));
      maybe_read();
    end else if (kind < 70) begin
      write_byte(ADDR_W'($urandom), CB_RESET);
    end else if (kind < 85) begin
      // good prefix of an erase, then a random write meant to break it
      k = $urandom_range(1, 5);
      for (int i = 0; i < k; i++)
        write_byte(unlock_at(prefix_b[i]), prefix_data[i]);
      write_byte($urandom_range(0, 1) ? unlock_at(1'($urandom_range(0, 1))) : ADDR_W'($urandom),
                 DATA_W'($urandom));
    end else begin
      write_byte(ADDR_W'($urandom), DATA_W'($urandom));
    end
  endtask

  task automatic random_phase(int count);
    int stop;
    stop = sent + count;
    while (sent < stop) begin
      if ($urandom_range(0, 29) == 0) tx_idle = ~tx_idle;
      if ($urandom_range(0, 29) == 0) rx_idle = ~rx_idle;
      random_sequence();
    end
  endtask

  initial begin
    access_ch.valid   = 1'b0;
    access_ch.command = CMD_READ;
    access_ch.address = '0;
    access_ch.data    = '0;
    hot[0] = '0;
    hot[1] = '1;
    for (int i = 2; i < 16; i++) hot[i] = ADDR_W'($urandom);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_ids(8'h00, 8'hFF);
    read_byte('0);
    write_byte(18'h12345, CB_RESET);
    write_byte('0, 8'hFF);
    unlock();
    write_byte(unlock_at(1'b0), CB_PROGRAM);
    write_byte('1, 8'h00);
    read_byte('1);
    unlock();
    write_byte(unlock_at(1'b0), CB_ID);
    read_byte(18'h00000);
    read_byte(18'h3FF01);
    read_byte(18'h00002);
    write_byte(unlock_at(1'b1), CB_UNLOCK2);
    write_byte('0, CB_RESET);
    // armed program takes even the reset byte as data
    unlock();
    write_byte(unlock_at(1'b0), CB_PROGRAM);
    write_byte(18'h15555, CB_RESET);
    read_byte(18'h15555);
    chip_erase();
    read_byte('1);
    read_byte(18'h15555);
    drain();

    set_ids(8'hFF, 8'h00);
    hold_req = 1'b1;
    random_phase(300);
    drain();

    set_ids(DATA_W'($urandom), DATA_W'($urandom));
    random_phase(150);
    drain();
    chip_erase();
    random_phase(150);
    drain();

    set_ids(MFR_ID_RST, DEV_ID_RST);
    hold_req = 1'b1;
    random_phase(200);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
